[src/assert_macros.svh]
// Assertion macros for the checker file of the project.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define RMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rmq_pkg.sv]
// Package for the range mex query block: field widths, opcodes, status codes.
// Depends on nothing.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 31;
    localparam int POS_W = 10;
    localparam int ST_W  = 2;
    localparam int MEX_W = 11;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

endpackage

[src/range_mex_query.sv]
// Range mex query engine: element store, mark bitmap and the sequencer that scans them.
// Depends on rmq_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: opcode, value, left_end, right_end.
//   Output channel out_valid/out_ready returns one item per input item: status, mex.
//   Append stores value (clamped to DEPTH) at the next position; clear empties the store.
//   Query returns the smallest non-negative value absent from positions left_end..right_end.
// Sequencing:
//   Append, clear, unused opcode and a rejected query: result registered on acceptance.
//   Valid query: the sequencer zeroes the mark bitmap, marks every value that the store
//   scan reads (one entry per cycle), then searches the bitmap for its first zero.
//   in_ready stays low until the result is registered.
// Reset:
//   rst_n clears the element count, the sequencer and the output valid. Store and marks
//   need no clearing pass; each query zeroes the marks before it scans.
// Stall:
//   A result waits in the output register while out_ready is low; in_ready is low then,
//   except in the cycle the waiting result is taken.
`timescale 1ns / 1ps

module range_mex_query #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rmq_pkg::OP_W-1:0]    opcode,
    input  logic [rmq_pkg::VAL_W-1:0]   value,
    input  logic [rmq_pkg::POS_W-1:0]   left_end,
    input  logic [rmq_pkg::POS_W-1:0]   right_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rmq_pkg::ST_W-1:0]    status,
    output logic [rmq_pkg::MEX_W-1:0]   mex
);
    import rmq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW = $clog2(DEPTH + 1);
    localparam int CW = VW;
    localparam int MW = $clog2(DEPTH + 2);
    localparam int KW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    logic            scan_pipe_reg, scan_pipe_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [ST_W-1:0] status_reg, status_next;
    logic [MEX_W-1:0] mex_reg, mex_next;
    logic [AW-1:0]   lo_reg, lo_next;
    logic [AW-1:0]   hi_reg, hi_next;
    logic [AW-1:0]   scan_idx_reg, scan_idx_next;
    logic [MW-1:0]   ctr_reg, ctr_next;
    logic [VW-1:0]   pend_addr_reg, pend_addr_next;

    logic [VW-1:0]   store_mem [DEPTH];
    logic [VW-1:0]   store_q;
    logic            marks_mem [DEPTH+1];
    logic            mark_q;

    logic            accept;
    logic            st_we;
    logic [VW-1:0]   st_wdata;
    logic            mk_we;
    logic [VW-1:0]   mk_waddr;
    logic            mk_wdata;
    logic            full;
    logic            bad_range;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign mex       = mex_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign bad_range = (left_end > right_end) || (KW'(right_end) >= KW'(count_reg));
    assign st_we     = accept && (opcode == OP_APPEND) && !full;
    assign st_wdata  = (32'(value) > 32'(DEPTH)) ? VW'(DEPTH) : VW'(value);
    assign mk_we     = (state_reg == S_CLR) || scan_pipe_reg;
    assign mk_waddr  = (state_reg == S_CLR) ? ctr_reg[VW-1:0] : store_q;
    assign mk_wdata  = (state_reg != S_CLR);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[count_reg[AW-1:0]] <= st_wdata;
        end
        store_q <= store_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mk_we)
        begin
            marks_mem[mk_waddr] <= mk_wdata;
        end
        mark_q <= marks_mem[ctr_reg[VW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        scan_pipe_next  = 1'b0;
        pend_valid_next = pend_valid_reg;
        status_next     = status_reg;
        mex_next        = mex_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        scan_idx_next   = scan_idx_reg;
        ctr_next        = ctr_reg;
        pend_addr_next  = pend_addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    mex_next    = '0;
                    case (opcode)
                        OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (bad_range)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_BAD_RANGE;
                            end
                            else
                            begin
                                lo_next    = AW'(left_end);
                                hi_next    = AW'(right_end);
                                ctr_next   = '0;
                                state_next = S_CLR;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                ctr_next = ctr_reg + MW'(1);
                if (ctr_reg == MW'(DEPTH))
                begin
                    scan_idx_next = lo_reg;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_pipe_next = 1'b1;
                if (scan_idx_reg == hi_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                ctr_next        = '0;
                pend_valid_next = 1'b0;
                state_next      = S_SRCH;
            end
            S_SRCH:
            begin
                if (pend_valid_reg && !mark_q)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = ST_OK;
                    mex_next        = MEX_W'(pend_addr_reg);
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    pend_addr_next  = ctr_reg[VW-1:0];
                    pend_valid_next = 1'b1;
                    ctr_next        = ctr_reg + MW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            scan_pipe_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            scan_pipe_reg  <= scan_pipe_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        mex_reg       <= mex_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        scan_idx_reg  <= scan_idx_next;
        ctr_reg       <= ctr_next;
        pend_addr_reg <= pend_addr_next;
    end

endmodule

[src/rmq_checker.sv]
// Port-level checker for range_mex_query, attached by the bind at the end of the file.
// Depends on rmq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rmq_pkg::ST_W-1:0]    status,
    input logic [rmq_pkg::MEX_W-1:0]   mex
);
    import rmq_pkg::*;

    `RMQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `RMQ_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(status) && $stable(mex), "result changed while stalled")
    `RMQ_ASSERT(a_busy_after_item, in_valid && in_ready |=> out_valid || !in_ready, "new item taken before the previous result")
    `RMQ_ASSERT(a_err_mex_zero, out_valid && (status != ST_OK) |-> mex == '0, "error result with nonzero mex")

endmodule

bind range_mex_query rmq_checker u_rmq_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for range_mex_query: directed, random, stalled items of all opcodes.
// Depends on rmq_pkg and range_mex_query; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;
    import rmq_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int RANDOM_ITEMS   = 500;
    localparam int PRESSURE_APPENDS = 16;
    localparam int PRESSURE_QUERIES = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam longint CYCLE_LIMIT = 10_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [MEX_W-1:0] mex;
    } mex_result_t;

    class mex_scoreboard;
        logic [MEX_W-1:0] elements [DEPTH];
        int unsigned      count;
        mex_result_t      pending_q [$];
        int unsigned      items;
        int unsigned      mismatches;
        int unsigned      appends;
        int unsigned      full_appends;
        int unsigned      good_queries;
        int unsigned      bad_queries;
        int unsigned      clears;
        int unsigned      unused_ops;
        int unsigned      max_mex;

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endfunction

        function logic [MEX_W-1:0] range_mex(int unsigned lo, int unsigned hi);
            bit [DEPTH:0] marks;
            int unsigned  k;
            marks = '0;
            for (k = lo; k <= hi; k++)
                marks[elements[k]] = 1'b1;
            for (k = 0; k <= DEPTH; k++)
                if (!marks[k])
                    return MEX_W'(k);
            return MEX_W'(DEPTH);
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
            mex_result_t res;
            res.status = ST_OK;
            res.mex    = '0;
            items++;
            case (op)
                OP_APPEND:
                    if (count >= DEPTH)
                    begin
                        res.status = ST_FULL;
                        full_appends++;
                    end
                    else
                    begin
                        elements[count] = (val > DEPTH) ? MEX_W'(DEPTH) : MEX_W'(val);
                        count++;
                        appends++;
                    end
                OP_QUERY:
                    if (lo > hi || hi >= count)
                    begin
                        res.status = ST_BAD_RANGE;
                        bad_queries++;
                    end
                    else
                    begin
                        res.mex = range_mex(lo, hi);
                        good_queries++;
                        if (res.mex > max_mex)
                            max_mex = res.mex;
                    end
                OP_CLEAR:
                begin
                    count = 0;
                    clears++;
                end
                default:
                    unused_ops++;
            endcase
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [ST_W-1:0] st, logic [MEX_W-1:0] mx);
            mex_result_t want;
            if (pending_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected item: status %0d mex %0d", st, mx));
                return;
            end
            want = pending_q.pop_front();
            if (st !== want.status)
                flag_mismatch($sformatf("status expected %0d got %0d", want.status, st));
            if (mx !== want.mex)
                flag_mismatch($sformatf("mex expected %0d got %0d", want.mex, mx));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode    = OP_APPEND;
    logic [VAL_W-1:0]     value     = '0;
    logic [POS_W-1:0]     left_end  = '0;
    logic [POS_W-1:0]     right_end = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ST_W-1:0]      status;
    logic [MEX_W-1:0]     mex;

    int unsigned          tx_idle_pct = 37;
    int unsigned          rx_idle_pct = 66;
    int unsigned          hold_asked  = 0;
    int unsigned          hold_served = 0;
    int unsigned          hold_left   = 0;
    longint unsigned      cycle_count = 0;
    mex_scoreboard        sb;

    range_mex_query #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .left_end  (left_end),
        .right_end (right_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .mex       (mex)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Hold off the result channel for a long stretch on request.
    always @(posedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, mex);
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        value     <= val;
        left_end  <= lo;
        right_end <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, val, lo, hi);
    endtask

    task automatic send_append(logic [VAL_W-1:0] val);
        send_item(OP_APPEND, val, POS_W'($urandom()), POS_W'($urandom()));
    endtask

    task automatic send_query(int unsigned lo, int unsigned hi);
        send_item(OP_QUERY, VAL_W'($urandom()), POS_W'(lo), POS_W'(hi));
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, VAL_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()));
    endtask

    function automatic logic [VAL_W-1:0] pick_value(int unsigned stored);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return VAL_W'($urandom_range(stored / 2 + 2));
        if (pick < 85)
            return VAL_W'($urandom_range(DEPTH + 2, DEPTH - 2));
        if (pick < 93)
            return VAL_W'($urandom_range(7));
        return VAL_W'($urandom());
    endfunction

    task automatic random_query(int unsigned stored);
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(99);
        if (stored != 0 && pick < 80)
        begin
            lo = $urandom_range(stored - 1);
            hi = $urandom_range(stored - 1, lo);
        end
        else if (pick < 88)
        begin
            hi = $urandom_range(POS_MAX - 1);
            lo = $urandom_range(POS_MAX, hi + 1);
        end
        else if (pick < 95 && stored <= POS_MAX)
        begin
            hi = $urandom_range(POS_MAX, stored);
            lo = $urandom_range(hi);
        end
        else
        begin
            lo = $urandom_range(POS_MAX);
            hi = $urandom_range(POS_MAX);
        end
        send_query(lo, hi);
    endtask

    task automatic random_episode();
        int unsigned steps;
        int unsigned pick;
        if ($urandom_range(99) < 75)
            send_clear();
        steps = $urandom_range(60, 10);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_append(pick_value(sb.count));
            else if (pick < 92)
                random_query(sb.count);
            else if (pick < 96)
                send_item(OP_UNUSED, VAL_W'($urandom()), POS_W'($urandom()),
                          POS_W'($urandom()));
            else
                send_clear();
        end
    endtask

    initial
    begin
        int unsigned      k;
        int unsigned      base;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, extremes, clamping, every opcode, bad ranges.
        send_query(0, 0);
        send_clear();
        send_item(OP_UNUSED, '1, POS_W'(POS_MAX), POS_W'(POS_MAX));
        send_append('1);
        send_append('0);
        send_append(VAL_W'(DEPTH));
        send_append(VAL_W'(DEPTH + 1));
        send_append(VAL_W'(1));
        send_append(VAL_W'(3));
        send_query(0, 0);
        send_query(1, 1);
        send_query(0, 5);
        send_query(4, 5);
        send_query(2, 1);
        send_query(0, 6);
        send_query(POS_MAX, POS_MAX);
        send_query(POS_MAX, 0);
        send_item(OP_UNUSED, '0, '0, '0);
        send_query(1, 5);
        send_clear();
        send_query(0, 0);
        send_append(VAL_W'(31'h2AAA_AAAA));
        send_append(VAL_W'(31'h5555_5555));
        send_query(0, 1);

        base = sb.items;
        while (sb.items - base < RANDOM_ITEMS)
        begin
            if (sb.items - base >= 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (sb.items - base >= RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 66;
                rx_idle_pct = 37;
            end
            random_episode();
        end

        // Fill part of the store with a permutation under a long result stall.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_clear();
        hold_asked++;
        for (k = 0; k < PRESSURE_APPENDS; k++)
            send_append(VAL_W'((k * 5) % PRESSURE_APPENDS));
        send_query(0, PRESSURE_APPENDS - 1);
        repeat (PRESSURE_QUERIES) random_query(sb.count);
        send_clear();
        send_query(0, 0);

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items: %0d appends, %0d to a full store, %0d clears, %0d unused",
                 sb.items, sb.appends, sb.full_appends, sb.clears, sb.unused_ops);
        $display("%0d queries answered (largest mex %0d), %0d rejected, %0d mismatches",
                 sb.good_queries, sb.max_mex, sb.bad_queries, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
